// ===== design/pitp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_pkg
// Shared types and constants of the prefixed integer text parser.
// ----------------------------------------------------------------------------
package pitp_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    localparam int unsigned BASE_BITS = 5;
    localparam int unsigned CHAR_BITS = 8;

    localparam logic [BASE_BITS-1:0] NOT_HEX  = 5'd16;
    localparam logic [BASE_BITS-1:0] BASE_HEX = 5'd16;
    localparam logic [BASE_BITS-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_BITS-1:0] DIGIT_TEN = 5'd10;

    localparam int unsigned Q_DEPTH    = 2;
    localparam int unsigned Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AFTER_ZERO,
        PH_AFTER_X,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic                 start;
        logic                 is_zero;
        logic                 is_x;
        logic [BASE_BITS-1:0] hex_val;
    } t_char_class;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic fire;
        logic emit;
    } t_back_status;

endpackage
`default_nettype wire

// ===== design/pitp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_front
// Classifies each incoming character: start flag, '0', 'x', hex digit value.
// ----------------------------------------------------------------------------
module pitp_front (
    input  wire logic [pitp_pkg::CHAR_BITS-1:0] i_char_code,
    input  wire logic                           i_start_req,
    output pitp_pkg::t_char_class               o_class
);

    logic [pitp_pkg::CHAR_BITS-1:0] w_diff;

    always_comb begin
        o_class.start   = i_start_req;
        o_class.is_zero = (i_char_code == pitp_pkg::CH_ZERO);
        o_class.is_x    = (i_char_code == pitp_pkg::CH_X_LO);
        w_diff          = '0;
        if (i_char_code inside {[pitp_pkg::CH_ZERO:pitp_pkg::CH_NINE]}) begin
            w_diff          = i_char_code - pitp_pkg::CH_ZERO;
            o_class.hex_val = w_diff[pitp_pkg::BASE_BITS-1:0];
        end else if (i_char_code inside {[pitp_pkg::CH_A_LO:pitp_pkg::CH_F_LO]}) begin
            w_diff          = i_char_code - pitp_pkg::CH_A_LO;
            o_class.hex_val = w_diff[pitp_pkg::BASE_BITS-1:0] + pitp_pkg::DIGIT_TEN;
        end else if (i_char_code inside {[pitp_pkg::CH_A_UP:pitp_pkg::CH_F_UP]}) begin
            w_diff          = i_char_code - pitp_pkg::CH_A_UP;
            o_class.hex_val = w_diff[pitp_pkg::BASE_BITS-1:0] + pitp_pkg::DIGIT_TEN;
        end else begin
            o_class.hex_val = pitp_pkg::NOT_HEX;
        end
    end

endmodule
`default_nettype wire

// ===== design/pitp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_queue
// Short FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module pitp_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire pitp_pkg::t_char_class i_data,
    input  wire logic                  i_pop,
    output pitp_pkg::t_char_class      o_data,
    output pitp_pkg::t_q_status        o_status
);

    pitp_pkg::t_char_class                r_mem [pitp_pkg::Q_DEPTH];
    logic [pitp_pkg::Q_PTR_BITS-1:0]      r_wr_ptr;
    logic [pitp_pkg::Q_PTR_BITS-1:0]      r_rd_ptr;
    logic [pitp_pkg::Q_CNT_BITS-1:0]      r_count;
    logic [pitp_pkg::Q_CNT_BITS-1:0]      n_count;

    localparam logic [pitp_pkg::Q_CNT_BITS-1:0] CntFull =
        pitp_pkg::Q_CNT_BITS'(pitp_pkg::Q_DEPTH);
    localparam logic [pitp_pkg::Q_PTR_BITS-1:0] PtrLast =
        pitp_pkg::Q_PTR_BITS'(pitp_pkg::Q_DEPTH - 1);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CntFull);
    assign o_status.empty = (r_count == '0);

endmodule
`default_nettype wire

// ===== design/pitp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_back
// Prefix and digit sequencer with multiply-add accumulator and output register.
// ----------------------------------------------------------------------------
module pitp_back #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [pitp_pkg::BASE_BITS-1:0] i_cfg_base,
    input  wire logic                           i_q_valid,
    input  wire pitp_pkg::t_char_class          i_q_data,
    output logic                                o_q_pop,
    input  wire logic                           i_ready,
    output logic                                o_valid,
    output logic [63:0]                         o_value,
    output logic [OFFSET_BITS-1:0]              o_end_offset,
    output pitp_pkg::t_back_status              o_status
);

    localparam logic [OFFSET_BITS-1:0] CountMax = '1;
    localparam logic [OFFSET_BITS-1:0] CountOne = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] CountTwo = OFFSET_BITS'(2);

    pitp_pkg::t_phase                r_phase;
    pitp_pkg::t_phase                n_phase;
    logic [63:0]                     r_acc;
    logic [63:0]                     n_acc;
    logic [pitp_pkg::BASE_BITS-1:0]  r_base;
    logic [pitp_pkg::BASE_BITS-1:0]  n_base;
    logic [OFFSET_BITS-1:0]          r_count;
    logic [OFFSET_BITS-1:0]          n_count;
    logic                            r_out_valid;
    logic [63:0]                     r_value;
    logic [OFFSET_BITS-1:0]          r_offset;

    logic                            w_fire;
    logic                            w_take;
    logic                            w_take_ok;
    logic                            w_emit;
    logic [63:0]                     w_acc_in;
    logic [pitp_pkg::BASE_BITS-1:0]  w_base_in;
    logic [OFFSET_BITS-1:0]          w_count_in;
    logic [63:0]                     w_product;
    logic                            w_is_hex;

    assign w_fire   = i_q_valid && (!r_out_valid || i_ready);
    assign w_is_hex = (i_q_data.hex_val != pitp_pkg::NOT_HEX);

    // operand selection per phase
    always_comb begin
        w_acc_in   = r_acc;
        w_base_in  = r_base;
        w_count_in = r_count;
        w_take     = 1'b0;
        if (i_q_data.start) begin
            w_acc_in   = '0;
            w_count_in = '0;
            w_base_in  = i_cfg_base;
            w_take     = !i_q_data.is_zero;
            if (!i_q_data.is_zero && i_cfg_base == '0) begin
                w_base_in = pitp_pkg::BASE_DEC;
            end
        end else begin
            case (r_phase)
                pitp_pkg::PH_AFTER_ZERO: begin
                    if (!i_q_data.is_x) begin
                        w_take = 1'b1;
                        if (r_base == '0) begin
                            w_base_in = pitp_pkg::BASE_OCT;
                        end
                    end
                end
                pitp_pkg::PH_AFTER_X: begin
                    if (w_is_hex) begin
                        w_take     = 1'b1;
                        w_base_in  = pitp_pkg::BASE_HEX;
                        w_count_in = CountTwo;
                    end else if (r_base == '0) begin
                        w_base_in = pitp_pkg::BASE_OCT;
                    end
                end
                pitp_pkg::PH_DIGITS: begin
                    w_take = 1'b1;
                end
                default: begin
                    w_take = 1'b0;
                end
            endcase
        end
        w_take_ok = w_take && (i_q_data.hex_val < w_base_in);
        w_emit    = w_fire && ((w_take && !w_take_ok) ||
                    (!i_q_data.start && r_phase == pitp_pkg::PH_AFTER_X && !w_is_hex));
    end

    assign w_product = w_acc_in * 64'(w_base_in);

    always_comb begin
        n_acc   = r_acc;
        n_base  = r_base;
        n_count = r_count;
        if (w_fire) begin
            n_acc   = w_acc_in;
            n_base  = w_base_in;
            n_count = (i_q_data.start && i_q_data.is_zero) ? CountOne : w_count_in;
            if (w_take_ok) begin
                n_acc   = w_product + 64'(i_q_data.hex_val);
                n_count = (w_count_in < CountMax) ? w_count_in + 1'b1 : w_count_in;
            end
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (i_q_data.start && i_q_data.is_zero) begin
                n_phase = pitp_pkg::PH_AFTER_ZERO;
            end else if (!i_q_data.start && r_phase == pitp_pkg::PH_AFTER_ZERO &&
                         i_q_data.is_x) begin
                n_phase = pitp_pkg::PH_AFTER_X;
            end else if (w_take_ok) begin
                n_phase = pitp_pkg::PH_DIGITS;
            end else if (w_emit) begin
                n_phase = pitp_pkg::PH_IDLE;
            end
        end
    end

    // outputs
    always_comb begin
        o_q_pop         = w_fire;
        o_status.fire   = w_fire;
        o_status.emit   = w_emit;
        o_valid         = r_out_valid;
        o_value         = r_value;
        o_end_offset    = r_offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pitp_pkg::PH_IDLE;
            r_acc       <= '0;
            r_base      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_count <= n_count;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_value  <= w_acc_in;
            r_offset <= w_count_in;
        end
    end

endmodule
`default_nettype wire

// ===== design/prefixed_integer_text_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prefixed_integer_text_parser
// Streaming unsigned integer parser with 0 / 0x prefix base detection.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the output is not stalled, set by
//   the back end's accumulator multiply-add (64 x 5 bits plus digit) on its feedback loop.
// Result path: the stopping character passes the queue stage, then the back
//   end registers the result into o_valid/o_value as it pops that character.
// Reset: synchronous, active low; parser idle, base register 0, queue empty.
// ----------------------------------------------------------------------------
module prefixed_integer_text_parser #(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [7:0]                     i_char_code,
    input  wire logic                           i_start_req,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [63:0]                         o_value,
    output logic [OFFSET_BITS-1:0]              o_end_offset,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pitp_pkg::BASE_BITS-1:0] i_cfg_base
);

    logic [pitp_pkg::BASE_BITS-1:0] r_base;
    pitp_pkg::t_char_class          w_class;
    pitp_pkg::t_char_class          w_q_data;
    pitp_pkg::t_q_status            w_q_status;
    pitp_pkg::t_back_status         w_back_status;
    logic                           w_push;
    logic                           w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_base;
        end
    end

    assign o_ready = !w_q_status.full;
    assign w_push  = i_valid && o_ready;

    pitp_front u_front (
        .i_char_code (i_char_code),
        .i_start_req (i_start_req),
        .o_class     (w_class)
    );

    pitp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_class),
        .i_pop    (w_pop),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    pitp_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_base   (r_base),
        .i_q_valid    (!w_q_status.empty),
        .i_q_data     (w_q_data),
        .o_q_pop      (w_pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_value      (o_value),
        .o_end_offset (o_end_offset),
        .o_status     (w_back_status)
    );

    a_q_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty at once");

    a_emit_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.emit |-> w_back_status.fire)
        else $error("result emitted without a queue pop");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_status.emit |=> o_valid)
        else $error("emitted result not presented");

    a_fire_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_back_status.fire)
        else $error("back end advanced while output stalled");

endmodule
`default_nettype wire

// ===== sim/prefixed_integer_text_parser_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prefixed_integer_text_parser_tb
// Self-checking bench for the prefixed integer text parser. Characters are
// fed over the input channel with random gaps and results are drained with
// random stalls. A scoreboard tracks the parser state per accepted character
// and compares each result, field by field, against its queue of expected
// numbers. A short directed pass covers the prefix forms, restart, idle input
// and odd bases. Random strings and noise follow, under changing bases, and
// the run ends with one long hex string.
// ----------------------------------------------------------------------------
module prefixed_integer_text_parser_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned CHAR_TARGET = 1260;
    localparam int unsigned LONG_RUN    = 40;
    localparam int unsigned SETTLE      = 4;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_G_LO = 8'h67;

    class parse_scoreboard;
        typedef struct packed {
            logic [63:0] value;
            logic [15:0] end_offset;
        } t_number;

        logic [pitp_pkg::BASE_BITS-1:0] base_reg;
        logic [63:0]                    acc;
        logic [pitp_pkg::BASE_BITS-1:0] act_base;
        pitp_pkg::t_phase               ph;
        logic [15:0]                    count;
        t_number                        expected_numbers[$];
        int unsigned                    errors;

        function new();
            base_reg = '0;
            acc      = '0;
            act_base = '0;
            ph       = pitp_pkg::PH_IDLE;
            count    = '0;
            errors   = 0;
        endfunction

        function void set_base(logic [pitp_pkg::BASE_BITS-1:0] b);
            base_reg = b;
        endfunction

        function int pending();
            return expected_numbers.size();
        endfunction

        static function logic [pitp_pkg::BASE_BITS-1:0] digit_of(logic [7:0] c);
            if (c >= pitp_pkg::CH_ZERO && c <= pitp_pkg::CH_NINE) begin
                return pitp_pkg::BASE_BITS'(c - pitp_pkg::CH_ZERO);
            end
            if (c >= pitp_pkg::CH_A_LO && c <= pitp_pkg::CH_F_LO) begin
                return pitp_pkg::BASE_BITS'(c - pitp_pkg::CH_A_LO) +
                       pitp_pkg::DIGIT_TEN;
            end
            if (c >= pitp_pkg::CH_A_UP && c <= pitp_pkg::CH_F_UP) begin
                return pitp_pkg::BASE_BITS'(c - pitp_pkg::CH_A_UP) +
                       pitp_pkg::DIGIT_TEN;
            end
            return pitp_pkg::NOT_HEX;
        endfunction

        function void close_number();
            t_number n;
            n.value      = acc;
            n.end_offset = count;
            expected_numbers.push_back(n);
            ph = pitp_pkg::PH_IDLE;
        endfunction

        function void take_digit(logic [pitp_pkg::BASE_BITS-1:0] dv);
            ph = pitp_pkg::PH_DIGITS;
            if (dv < act_base) begin
                acc = acc * 64'(act_base) + 64'(dv);
                if (count != 16'hFFFF) begin
                    count++;
                end
            end else begin
                close_number();
            end
        endfunction

        // returns 0 when the character is dropped by an idle parser
        function bit take_char(logic [7:0] c, bit s);
            logic [pitp_pkg::BASE_BITS-1:0] dv;
            dv = digit_of(c);
            if (s) begin
                acc      = '0;
                count    = '0;
                act_base = base_reg;
                if (c == pitp_pkg::CH_ZERO) begin
                    count = 16'd1;
                    ph    = pitp_pkg::PH_AFTER_ZERO;
                    return 1'b1;
                end
                if (act_base == '0) begin
                    act_base = pitp_pkg::BASE_DEC;
                end
                take_digit(dv);
                return 1'b1;
            end
            case (ph)
                pitp_pkg::PH_AFTER_ZERO: begin
                    if (c == pitp_pkg::CH_X_LO) begin
                        ph = pitp_pkg::PH_AFTER_X;
                    end else begin
                        if (act_base == '0) begin
                            act_base = pitp_pkg::BASE_OCT;
                        end
                        take_digit(dv);
                    end
                end
                pitp_pkg::PH_AFTER_X: begin
                    if (dv != pitp_pkg::NOT_HEX) begin
                        act_base = pitp_pkg::BASE_HEX;
                        count    = 16'd2;
                        take_digit(dv);
                    end else begin
                        if (act_base == '0) begin
                            act_base = pitp_pkg::BASE_OCT;
                        end
                        close_number();
                    end
                end
                pitp_pkg::PH_DIGITS: begin
                    take_digit(dv);
                end
                default: begin
                    return 1'b0;
                end
            endcase
            return 1'b1;
        endfunction

        function void match_number(logic [63:0] value, logic [15:0] end_offset);
            t_number n;
            if (expected_numbers.size() == 0) begin
                $error("unexpected result: value %h end_offset %0d", value, end_offset);
                errors++;
                return;
            end
            n = expected_numbers.pop_front();
            if (value !== n.value) begin
                $error("value: expected %h, actual %h", n.value, value);
                errors++;
            end
            if (end_offset !== n.end_offset) begin
                $error("end_offset: expected %0d, actual %0d", n.end_offset, end_offset);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk        = 1'b0;
    logic                           i_rst_n      = 1'b0;
    logic                           i_valid      = 1'b0;
    logic                           o_ready;
    logic [7:0]                     i_char_code  = '0;
    logic                           i_start_req  = 1'b0;
    logic                           o_valid;
    logic                           i_ready      = 1'b0;
    logic [63:0]                    o_value;
    logic [15:0]                    o_end_offset;
    logic                           i_cfg_valid  = 1'b0;
    logic                           o_cfg_ready;
    logic [pitp_pkg::BASE_BITS-1:0] i_cfg_base   = '0;

    parse_scoreboard sb = new();

    bit          quiet       = 1'b0;
    int unsigned fed_chars   = 0;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;

    prefixed_integer_text_parser #(
        .OFFSET_BITS(16)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_end_offset(o_end_offset),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_base  (i_cfg_base)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.match_number(o_value, o_end_offset);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            stall_left = quiet ? 0 : idle_len();
            if (stall_left == 0) begin
                i_ready <= 1'b1;
            end else begin
                stall_left--;
                i_ready <= 1'b0;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input bit s);
        int unsigned gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_start_req <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (sb.take_char(c, s)) begin
            fed_chars++;
        end
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_char(t[i], i == 0);
        end
    endtask

    // hold the sender until every expected number is out, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [pitp_pkg::BASE_BITS-1:0] b);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_base  <= b;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_base(b);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [pitp_pkg::BASE_BITS-1:0] pick_base();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 5'd1;
            2: return pitp_pkg::BASE_HEX;
            3: return '1;
            default: return pitp_pkg::BASE_BITS'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(int unsigned v);
        if (v < 10) begin
            return pitp_pkg::CH_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? pitp_pkg::CH_A_LO : pitp_pkg::CH_A_UP) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] digit_char(int unsigned eb);
        return hex_char($urandom_range(0, (eb > 16 ? 16 : eb) - 1));
    endfunction

    function automatic logic [7:0] stop_char(int unsigned eb);
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: return CH_NUL;
            1: return 8'($urandom_range(0, 255));
            2: return CH_X_UP;
            3: return (eb < 16) ? hex_char($urandom_range(eb, 15)) : CH_G_LO;
            4: return pitp_pkg::CH_X_LO;
            default: begin
                do c = 8'($urandom_range(0, 255));
                while (parse_scoreboard::digit_of(c) != pitp_pkg::NOT_HEX);
                return c;
            end
        endcase
    endfunction

    task automatic send_number();
        int unsigned style;
        int unsigned eb;
        int unsigned ndig;
        style = $urandom_range(0, 19);
        ndig  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        if (style < 8) begin
            eb = (sb.base_reg == '0) ? 10 : sb.base_reg;
            send_char(digit_char(eb), 1'b1);
        end else if (style < 13) begin
            eb = (sb.base_reg == '0) ? 8 : sb.base_reg;
            send_char(pitp_pkg::CH_ZERO, 1'b1);
        end else begin
            eb = 16;
            send_char(pitp_pkg::CH_ZERO, 1'b1);
            send_char(pitp_pkg::CH_X_LO, 1'b0);
            if (style == 19) begin
                ndig = 0;
            end
        end
        repeat (ndig) send_char(digit_char(eb), 1'b0);
        if ($urandom_range(0, 9) != 0) begin
            send_char(stop_char(eb), 1'b0);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: prefixes, restart, idle input, odd bases
        write_base('0);
        send_text("123");
        send_char(CH_NUL, 1'b0);
        send_text("0179");
        send_text("0x1F");
        send_char(8'hFF, 1'b0);
        send_text("0xg");
        send_text("0X");
        send_char(pitp_pkg::CH_ZERO + 8'd5, 1'b0);
        send_text("78");
        send_text("4.");
        write_base(5'd1);
        send_text("001");
        write_base('1);
        send_text("fFz");
        send_text("0xg");

        fed_chars = 0;
        while (fed_chars < CHAR_TARGET) begin
            if ($urandom_range(0, 29) == 0) begin
                write_base(pick_base());
            end else if ($urandom_range(0, 49) == 0) begin
                drain();
            end
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 85) begin
                send_number();
            end else begin
                send_noise();
            end
        end
        quiet = 1'b0;

        // long string: all-ones value
        write_base(pitp_pkg::BASE_HEX);
        quiet = 1'b1;
        send_char(pitp_pkg::CH_F_LO, 1'b1);
        repeat (LONG_RUN - 1) send_char(pitp_pkg::CH_F_UP, 1'b0);
        send_char(CH_NUL, 1'b0);
        quiet = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== prefixed_integer_text_parser.f =====
design/pitp_pkg.sv
design/pitp_front.sv
design/pitp_queue.sv
design/pitp_back.sv
design/prefixed_integer_text_parser.sv
sim/prefixed_integer_text_parser_tb.sv
